### rtl/core/bpdc_pkg.sv
// Shared types, constants and classification function for the button press classifier.
`default_nettype none

package bpdc_pkg;

   // Widths of the tick timestamp and of the settle counters
   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int TICK_WIDTH  = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACTIVE_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SHORT_TICKS    = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MEDIUM_TICKS   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG_TICKS     = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HANDLER_ENABLE = 3'd5;

   // Press classes
   localparam logic [1:0] CLASS_SHORT  = 2'd0;
   localparam logic [1:0] CLASS_MEDIUM = 2'd1;
   localparam logic [1:0] CLASS_LONG   = 2'd2;

   // Debouncer phase
   typedef enum logic [1:0] {
      PH_UP      = 2'd0,
      PH_FALLING = 2'd1,
      PH_DOWN    = 2'd2,
      PH_RISING  = 2'd3
   } phase_type;

   typedef struct packed {
      logic                  mode;
      logic                  active_level;
      logic [TICK_WIDTH-1:0] short_ticks;
      logic [TICK_WIDTH-1:0] medium_ticks;
      logic [TICK_WIDTH-1:0] long_ticks;
      logic [2:0]            handler_enable;
   } cfg_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] press_class;
   } result_type;

   // Classes tried in order: short, medium, long
   function automatic result_type classify(input logic [TIME_WIDTH-1:0] d,
                                           input logic with_long,
                                           input cfg_type cfg);
      result_type             res;
      logic [TIME_WIDTH-1:0]  s_t;
      logic [TIME_WIDTH-1:0]  m_t;
      logic [TIME_WIDTH-1:0]  l_t;
      s_t = TIME_WIDTH'(cfg.short_ticks);
      m_t = TIME_WIDTH'(cfg.medium_ticks);
      l_t = TIME_WIDTH'(cfg.long_ticks);
      res.hit = 1'b0;
      res.press_class = CLASS_SHORT;
      priority if (d >= s_t && d <= m_t && cfg.handler_enable[0]) begin
         res.hit = 1'b1;
         res.press_class = CLASS_SHORT;
      end else if (d >= m_t && (!with_long || d <= l_t) && cfg.handler_enable[1]) begin
         res.hit = 1'b1;
         res.press_class = CLASS_MEDIUM;
      end else if (with_long && d >= l_t && cfg.handler_enable[2]) begin
         res.hit = 1'b1;
         res.press_class = CLASS_LONG;
      end else begin
         // no enabled class matches: no report
         res.hit = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/core/button_press_duration_classifier.sv
// Top level of the button press duration classifier: channels, registers, pipeline.
//
// Usage:
//   req channel: one word per pin sample (polled mode) or pin edge event (edge
//   mode), carrying the pin level and the current tick time.
//   rsp channel: one word per classified press (0 short, 1 medium, 2 long),
//   sent only for classes enabled in handler_enable; most words give none.
//   csr channel: register writes by index (0 mode, 1 active_level,
//   2 short_ticks, 3 medium_ticks, 4 long_ticks, 5 handler_enable), always
//   ready; indexes beyond the list are ignored. Write only while idle.
// Result path: a req word waits in the input register, and its result is held
//   in the result register before it shows on rsp.
// Throughput: one req word per cycle while rsp is not held; the input register
//   and the result register form two stages.
// Reset: registers return to their defaults, the debouncer to released,
//   press time and settle counters to zero; no clearing pass is needed.
// Stall: while rsp is held, one more word can wait in the input register;
//   after that req_ready drops until the result is taken.
`default_nettype none

module button_press_duration_classifier
   import bpdc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // input words
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_pin_level,
   input  wire logic [TIME_WIDTH-1:0]     req_time_now,
   // result words
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [1:0]                     rsp_press_class,
   // register writes
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data
);

   cfg_type               cfg_ff;
   logic                  in_valid_ff;
   logic                  in_pin_ff;
   logic [TIME_WIDTH-1:0] in_time_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_class_ff;
   logic                  advance;
   result_type            result;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= 1'b0;
         cfg_ff.active_level   <= 1'b0;
         cfg_ff.short_ticks    <= TICK_WIDTH'(5);
         cfg_ff.medium_ticks   <= TICK_WIDTH'(50);
         cfg_ff.long_ticks     <= TICK_WIDTH'(300);
         cfg_ff.handler_enable <= 3'b111;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:           cfg_ff.mode           <= csr_data[0];
            CSR_ACTIVE_LEVEL:   cfg_ff.active_level   <= csr_data[0];
            CSR_SHORT_TICKS:    cfg_ff.short_ticks    <= csr_data[TICK_WIDTH-1:0];
            CSR_MEDIUM_TICKS:   cfg_ff.medium_ticks   <= csr_data[TICK_WIDTH-1:0];
            CSR_LONG_TICKS:     cfg_ff.long_ticks     <= csr_data[TICK_WIDTH-1:0];
            CSR_HANDLER_ENABLE: cfg_ff.handler_enable <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Stage handshake: input word moves on when the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_pin_ff  <= req_pin_level;
         in_time_ff <= req_time_now;
      end
   end

   bpdc_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .pin_level (in_pin_ff),
      .time_now  (in_time_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result.hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.hit) begin
         rsp_class_ff <= result.press_class;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_class = rsp_class_ff;

endmodule

`default_nettype wire

### rtl/core/bpdc_fsm.sv
// Debounce / edge state machine with press timestamp and duration classification.
`default_nettype none

module bpdc_fsm
   import bpdc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  pin_level,
   input  wire logic [TIME_WIDTH-1:0] time_now,
   input  wire cfg_type               cfg,
   output result_type                 result
);

   phase_type              phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]  press_time_ff, press_time_in;
   logic [COUNT_WIDTH-1:0] fall_count_ff, fall_count_in;
   logic [COUNT_WIDTH-1:0] rise_count_ff, rise_count_in;

   logic                  pressed;
   logic [TIME_WIDTH-1:0] duration;
   logic                  fall_done;
   logic                  rise_done;
   logic [COUNT_WIDTH-1:0] fall_up;
   logic [COUNT_WIDTH-1:0] rise_up;

   assign pressed  = (pin_level == cfg.active_level);
   assign duration = time_now - press_time_ff;
   assign fall_done = CMP_WIDTH'(fall_count_ff) >= CMP_WIDTH'(cfg.short_ticks);
   assign rise_done = CMP_WIDTH'(rise_count_ff) >= CMP_WIDTH'(cfg.short_ticks);
   // saturating count up; after a decision the counter restarts at one
   assign fall_up = fall_done ? COUNT_WIDTH'(1) :
                    (&fall_count_ff) ? fall_count_ff : fall_count_ff + COUNT_WIDTH'(1);
   assign rise_up = rise_done ? COUNT_WIDTH'(1) :
                    (&rise_count_ff) ? rise_count_ff : rise_count_ff + COUNT_WIDTH'(1);

   // Next state
   always_comb begin
      phase_in      = phase_ff;
      press_time_in = press_time_ff;
      fall_count_in = fall_count_ff;
      rise_count_in = rise_count_ff;
      if (cfg.mode) begin
         // edge events: up/falling wait for press, down/rising wait for release
         if (phase_ff == PH_UP || phase_ff == PH_FALLING) begin
            if (pressed) begin
               press_time_in = time_now;
               phase_in      = PH_RISING;
            end
         end else begin
            phase_in = PH_FALLING;
         end
      end else begin
         unique case (phase_ff)
            PH_UP: begin
               if (pressed) phase_in = PH_FALLING;
            end
            PH_DOWN: begin
               if (!pressed) phase_in = PH_RISING;
            end
            PH_FALLING: begin
               if (fall_done) begin
                  if (pressed) begin
                     phase_in      = PH_DOWN;
                     press_time_in = time_now;
                  end else begin
                     phase_in = PH_UP;
                  end
               end
               fall_count_in = fall_up;
            end
            PH_RISING: begin
               if (rise_done) begin
                  phase_in = pressed ? PH_DOWN : PH_UP;
               end
               rise_count_in = rise_up;
            end
            default: begin
               phase_in = PH_UP;
            end
         endcase
      end
   end

   // Outputs: report on a confirmed release
   always_comb begin
      result = '0;
      if (cfg.mode) begin
         if ((phase_ff == PH_DOWN || phase_ff == PH_RISING) && !pressed) begin
            result = classify(duration, 1'b1, cfg);
         end
      end else if (phase_ff == PH_RISING && rise_done && !pressed) begin
         result = classify(duration, 1'b0, cfg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_UP;
         press_time_ff <= '0;
         fall_count_ff <= '0;
         rise_count_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         press_time_ff <= press_time_in;
         fall_count_ff <= fall_count_in;
         rise_count_ff <= rise_count_in;
      end
   end

endmodule

`default_nettype wire

### sim/tb_button_press_duration_classifier.sv
// Self-checking testbench for the button press duration classifier (polled and edge modes).
module tb_button_press_duration_classifier;
   import bpdc_pkg::*;

   localparam int STALL_LIMIT   = 5000;  // cycles with no handshake at all
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 4;     // pipeline is two stages deep
   localparam int END_CYCLES    = 20;
   localparam int PHASE_WORDS   = 110;

   // indexes past the register list, writes there must be dropped
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_pin_level;
   logic [TIME_WIDTH-1:0]     req_time_now;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [1:0]                rsp_press_class;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   // register copies
   logic                      cfg_mode;
   logic                      cfg_active;
   logic [TICK_WIDTH-1:0]     cfg_short;
   logic [TICK_WIDTH-1:0]     cfg_medium;
   logic [TICK_WIDTH-1:0]     cfg_long;
   logic [2:0]                cfg_enable;

   // debouncer state as the block should hold it
   phase_type                 btn_phase;
   logic [TIME_WIDTH-1:0]     press_stamp;
   logic [COUNT_WIDTH-1:0]    fall_settle;
   logic [COUNT_WIDTH-1:0]    rise_settle;

   logic [1:0]                pending_classes[$];
   int                        mismatches = 0;
   int                        quiet_cycles = 0;
   int                        words_sent = 0;
   logic [TIME_WIDTH-1:0]     tick;

   // idling controls
   logic                      req_gaps = 1'b1;
   logic                      rsp_stalls = 1'b1;
   logic                      hold_req = 1'b0;
   logic                      rsp_holding = 1'b0;

   button_press_duration_classifier u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pin_level   (req_pin_level),
      .req_time_now    (req_time_now),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_press_class (rsp_press_class),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [COUNT_WIDTH-1:0] settle_step(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   // -1 when no enabled class matches
   function automatic int grade_press(input logic [TIME_WIDTH-1:0] span, input logic with_long);
      if (span >= cfg_short && span <= cfg_medium && cfg_enable[0])
         return CLASS_SHORT;
      if (span >= cfg_medium && (!with_long || span <= cfg_long) && cfg_enable[1])
         return CLASS_MEDIUM;
      if (with_long && span >= cfg_long && cfg_enable[2])
         return CLASS_LONG;
      return -1;
   endfunction

   task automatic track_sample(input logic pin, input logic [TIME_WIDTH-1:0] now);
      logic held;
      int   grade;
      held  = (pin == cfg_active);
      grade = -1;
      if (cfg_mode) begin
         // edge events: up/falling wait for a press, down/rising for a release
         if (btn_phase == PH_UP || btn_phase == PH_FALLING) begin
            if (held) begin
               press_stamp = now;
               btn_phase   = PH_RISING;
            end
         end else begin
            if (!held)
               grade = grade_press(now - press_stamp, 1'b1);
            btn_phase = PH_FALLING;
         end
      end else begin
         case (btn_phase)
            PH_UP: begin
               if (held)
                  btn_phase = PH_FALLING;
            end
            PH_DOWN: begin
               if (!held)
                  btn_phase = PH_RISING;
            end
            PH_FALLING: begin
               if (fall_settle >= cfg_short) begin
                  if (held) begin
                     btn_phase   = PH_DOWN;
                     press_stamp = now;
                  end else begin
                     btn_phase = PH_UP;
                  end
                  fall_settle = '0;
               end
               fall_settle = settle_step(fall_settle);
            end
            default: begin
               if (rise_settle >= cfg_short) begin
                  if (!held) begin
                     btn_phase = PH_UP;
                     grade     = grade_press(now - press_stamp, 1'b0);
                  end else begin
                     btn_phase = PH_DOWN;
                  end
                  rise_settle = '0;
               end
               rise_settle = settle_step(rise_settle);
            end
         endcase
      end
      if (grade >= 0)
         pending_classes.push_back(2'(grade));
   endtask

   // ---------------------------------------------------------------- scoreboard

   // all handshakes seen at the rising edge, in one place
   always @(posedge clock) begin : scoreboard
      logic [1:0] want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:           cfg_mode   = csr_data[0];
               CSR_ACTIVE_LEVEL:   cfg_active = csr_data[0];
               CSR_SHORT_TICKS:    cfg_short  = csr_data[TICK_WIDTH-1:0];
               CSR_MEDIUM_TICKS:   cfg_medium = csr_data[TICK_WIDTH-1:0];
               CSR_LONG_TICKS:     cfg_long   = csr_data[TICK_WIDTH-1:0];
               CSR_HANDLER_ENABLE: cfg_enable = csr_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            track_sample(req_pin_level, req_time_now);
         if (rsp_valid && rsp_ready) begin
            if (pending_classes.size() == 0) begin
               $display("%0t: result word with none expected: press_class got %0d",
                        $time, rsp_press_class);
               mismatches++;
            end else begin
               want = pending_classes.pop_front();
               if (rsp_press_class !== want) begin
                  $display("%0t: press_class mismatch: expected %0d, got %0d",
                           $time, want, rsp_press_class);
                  mismatches++;
               end
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------- drivers

   // mostly back to back, some short pauses, a few long ones
   function automatic int gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, or one long hold-off on request
   initial begin : rsp_side
      int g;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready   = 1'b0;
            rsp_holding = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req    = 1'b0;
            rsp_holding = 1'b0;
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
            g = rsp_stalls ? gap_length() : 0;
            if (g > 0) begin
               rsp_ready = 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
   end

   // called at a falling edge; valid stays up when no gap follows
   task automatic send_word(input logic pin, input logic [TIME_WIDTH-1:0] now);
      int g;
      req_valid     = 1'b1;
      req_pin_level = pin;
      req_time_now  = now;
      do begin
         @(posedge clock);
      end while (req_ready !== 1'b1);
      words_sent++;
      @(negedge clock);
      g = req_gaps ? gap_length() : 0;
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do begin
         @(posedge clock);
      end while (csr_ready !== 1'b1);
      @(negedge clock);
   endtask

   // narrow registers get random upper data bits, which the block drops
   task automatic configure(input logic md, input logic lvl,
                            input logic [TICK_WIDTH-1:0] s, input logic [TICK_WIDTH-1:0] m,
                            input logic [TICK_WIDTH-1:0] l, input logic [2:0] en);
      write_reg(CSR_MODE, {15'($urandom), md});
      write_reg(CSR_ACTIVE_LEVEL, {15'($urandom), lvl});
      write_reg(CSR_SHORT_TICKS, s);
      write_reg(CSR_MEDIUM_TICKS, m);
      write_reg(CSR_LONG_TICKS, l);
      write_reg(CSR_HANDLER_ENABLE, {13'($urandom), en});
      csr_valid = 1'b0;
   endtask

   // stop offering words and wait until every expected result is back
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_classes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // press length aimed at a class boundary half of the time
   function automatic logic [TIME_WIDTH-1:0] span_pick();
      case ($urandom_range(0, 9))
         0:       return cfg_short + $urandom_range(0, 2) - 1;
         1, 2:    return cfg_medium + $urandom_range(0, 2) - 1;
         3, 4:    return cfg_long + $urandom_range(0, 2) - 1;
         5:       return $urandom_range(0, 3);
         6:       return $urandom;
         default: return $urandom_range(0, cfg_long + 16);
      endcase
   endfunction

   // polled press: optional glitch, hold past the settle window, release likewise
   task automatic polled_episode();
      int   settle;
      int   n;
      int   i;
      logic lvl;
      lvl    = cfg_active;
      settle = (cfg_short > 8) ? 8 : cfg_short;
      if ($urandom_range(0, 3) == 0) begin
         send_word(lvl, tick);
         tick++;
         send_word(~lvl, tick);
         tick++;
      end
      n = settle + $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         send_word(lvl, tick);
         tick += $urandom_range(0, 1);
      end
      tick += span_pick();
      n = settle + $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         send_word(~lvl, tick);
         tick += $urandom_range(0, 1);
      end
   endtask

   // edge press and release, sometimes with a stray event
   task automatic edge_episode();
      logic lvl;
      lvl = cfg_active;
      if ($urandom_range(0, 7) == 0)
         send_word(~lvl, tick);
      send_word(lvl, tick);
      tick += span_pick();
      if ($urandom_range(0, 7) == 0) begin
         // a second press event ends the release wait without a report
         send_word(lvl, tick);
         tick += $urandom_range(0, 3);
      end
      send_word(~lvl, tick);
      tick += $urandom_range(1, 20);
   endtask

   task automatic noise_burst();
      int n;
      int i;
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 1))
            tick = $urandom;
         send_word($urandom_range(0, 1), tick);
         tick += $urandom_range(0, 2);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // register defaults after reset: polled, active low, settle 5, medium from 50
   task automatic test_polled_defaults();
      int i;
      tick = 32'hFFFF_FFC0;
      // one pressed sample, then released through the settle window: rejected
      send_word(1'b0, tick);
      tick++;
      for (i = 0; i < 6; i++) begin
         send_word(1'b1, tick);
         tick++;
      end
      // real press; settle count now restarts from one
      for (i = 0; i < 6; i++) begin
         send_word(1'b0, tick);
         tick++;
      end
      tick += 52;
      // release crosses the time wrap, medium press
      for (i = 0; i < 7; i++) begin
         send_word(1'b1, tick);
         tick++;
      end
      drain_results();
   endtask

   // edge events: each class, wrap, too short, stray events, time extremes
   task automatic test_edge_events();
      write_reg(CSR_SPARE_LO, 16'($urandom));
      write_reg(CSR_SPARE_HI, 16'($urandom));
      configure(1'b1, 1'b1, 16'd10, 16'd100, 16'd1000, 3'd7);
      send_word(1'b0, 32'd5);             // release while up: ignored
      send_word(1'b1, 32'hFFFF_FFF0);
      send_word(1'b0, 32'h0000_0020);     // wraps, short
      send_word(1'b1, 32'd100);
      send_word(1'b1, 32'd150);           // press while waiting for release
      send_word(1'b1, 32'd200);           // fresh press from falling
      send_word(1'b0, 32'd500);           // medium
      send_word(1'b1, 32'd0);
      send_word(1'b0, 32'hFFFF_FFFF);     // long
      send_word(1'b1, 32'd7);
      send_word(1'b0, 32'd9);             // below short: no report
      drain_results();
   endtask

   // receiver holds off while the sender keeps going, block must stall req
   task automatic test_result_backpressure();
      int i;
      configure(1'b1, 1'b1, 16'd0, 16'd8, 16'd16, 3'd7);
      req_gaps = 1'b0;
      hold_req = 1'b1;
      while (!rsp_holding)
         @(negedge clock);
      tick = $urandom;
      for (i = 0; i < 20; i++) begin
         send_word(1'b1, tick);
         tick += $urandom_range(0, 24);
         send_word(1'b0, tick);
         tick++;
      end
      drain_results();
      req_gaps = 1'b1;
   endtask

   // several register settings, extremes first, then random ones
   task automatic test_random_settings();
      int                    k;
      int                    goal;
      logic                  md;
      logic                  lvl;
      logic [TICK_WIDTH-1:0] s;
      logic [TICK_WIDTH-1:0] m;
      logic [TICK_WIDTH-1:0] l;
      logic [2:0]            en;
      for (k = 0; k < 8; k++) begin
         case (k)
            0: configure(1'b0, 1'b0, '0, '0, '0, 3'd7);
            1: configure(1'b1, 1'b1, '1, '1, '1, 3'd7);
            2: configure(1'b0, 1'b1, 16'd3, 16'd20, '1, 3'd2);
            default: begin
               md  = $urandom_range(0, 1);
               lvl = $urandom_range(0, 1);
               s   = md ? $urandom_range(0, 40) : $urandom_range(0, 6);
               // thresholds sometimes out of order
               m   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, s) : s + $urandom_range(0, 60);
               l   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : m + $urandom_range(0, 200);
               en  = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
               configure(md, lvl, s, m, l, en);
            end
         endcase
         // one setting runs with no idling on either side
         req_gaps   = (k != 3);
         rsp_stalls = (k != 3);
         tick       = $urandom;
         goal       = words_sent + PHASE_WORDS;
         while (words_sent < goal) begin
            if ($urandom_range(0, 9) < 8) begin
               if (cfg_mode)
                  edge_episode();
               else
                  polled_episode();
            end else begin
               noise_burst();
            end
         end
         drain_results();
      end
      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pin_level = 1'b0;
      req_time_now  = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_MODE;
      csr_data      = '0;
      cfg_mode      = 1'b0;
      cfg_active    = 1'b0;
      cfg_short     = 16'd5;
      cfg_medium    = 16'd50;
      cfg_long      = 16'd300;
      cfg_enable    = 3'd7;
      btn_phase     = PH_UP;
      press_stamp   = '0;
      fall_settle   = '0;
      rise_settle   = '0;
      tick          = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_polled_defaults();
      test_edge_events();
      test_result_backpressure();
      test_random_settings();

      drain_results();
      repeat (END_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_classes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### button_press_duration_classifier.f
rtl/core/bpdc_pkg.sv
rtl/core/bpdc_fsm.sv
rtl/core/button_press_duration_classifier.sv
sim/tb_button_press_duration_classifier.sv
